[rtl/urlencoded_pair_parser_top_assert.svh]
// Assertion macros shared by the form string parser modules.
`ifndef URLENCODED_PAIR_PARSER_TOP_ASSERT_SVH
`define URLENCODED_PAIR_PARSER_TOP_ASSERT_SVH

`ifndef SYNTH

// Same-cycle implication, checked at every rising clock edge out of reset.
`define URLP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: implication check failed");

// Next-cycle implication, checked at every rising clock edge out of reset.
`define URLP_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: next-cycle check failed");

`else

`define URLP_ASSERT_IMPLY(label, clk, rst, ante, cons)
`define URLP_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

[rtl/urlp_pkg.sv]
// Types, character constants and the escape decoder of the form string parser.
`timescale 1ns / 1ps

package urlp_pkg;

   // Most results one input word can cause: byte or abort, verdict, stream end.
   localparam int MAX_RESULTS = 3;

   // Characters with a meaning in the encoded string.
   localparam logic [7:0] CH_PERCENT = 8'h25;
   localparam logic [7:0] CH_PLUS    = 8'h2B;
   localparam logic [7:0] CH_EQUAL   = 8'h3D;
   localparam logic [7:0] CH_SEMI    = 8'h3B;
   localparam logic [7:0] CH_AMP     = 8'h26;
   localparam logic [7:0] CH_SPACE   = 8'h20;
   localparam logic [7:0] CH_ZERO    = 8'h30;
   localparam logic [7:0] CH_NINE    = 8'h39;
   localparam logic [7:0] CH_LOWER_A = 8'h61;
   localparam logic [7:0] CH_LOWER_F = 8'h66;
   localparam logic [7:0] CH_UPPER_A = 8'h41;
   localparam logic [7:0] CH_UPPER_F = 8'h46;

   typedef enum logic [2:0] {
      KIND_KEY    = 3'd0,
      KIND_VAL    = 3'd1,
      KIND_COMMIT = 3'd2,
      KIND_DROP   = 3'd3,
      KIND_ABORT  = 3'd4,
      KIND_END    = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      PH_SKIP  = 2'd0,
      PH_KEY   = 2'd1,
      PH_VALUE = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      HEX_IDLE   = 2'd0,
      HEX_FIRST  = 2'd1,
      HEX_SECOND = 2'd2
   } hex_type;

   typedef enum logic [1:0] {
      DEC_NONE  = 2'd0,
      DEC_BYTE  = 2'd1,
      DEC_ERROR = 2'd2
   } outcome_type;

   // One result word as it travels to the output queue.
   typedef struct packed {
      kind_type   kind;
      logic [7:0] data;
      logic [1:0] cls;
      logic       run_last;
   } result_type;

   // The results of one input word, written to the queue together.
   typedef struct packed {
      logic [1:0]                   count;
      result_type [MAX_RESULTS-1:0] entry;
   } push_type;

   // Outcome of feeding one character through the escape decoder.
   typedef struct packed {
      outcome_type outcome;
      logic [7:0]  data;
      hex_type     step;
      logic [3:0]  high;
   } decode_type;

   // Hex digit value with a valid flag in the top bit.
   function automatic logic [4:0] hex_nibble(input logic [7:0] c);
      logic [4:0] v;
      v = 5'd0;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = {1'b1, c[3:0]};
      end else if ((c >= CH_LOWER_A && c <= CH_LOWER_F) ||
                   (c >= CH_UPPER_A && c <= CH_UPPER_F)) begin
         v = {1'b1, c[3:0] + 4'd9};
      end
      return v;
   endfunction

   // Percent and plus decoding of one character given the escape state.
   function automatic decode_type decode_char(input logic [7:0] c, input hex_type step,
                                              input logic [3:0] high);
      decode_type d;
      logic [4:0] nib;
      d.outcome = DEC_NONE;
      d.data    = 8'd0;
      d.step    = step;
      d.high    = high;
      nib       = hex_nibble(c);
      if (step == HEX_IDLE) begin
         if (c == CH_PERCENT) begin
            d.step = HEX_FIRST;
         end else begin
            d.outcome = DEC_BYTE;
            d.data    = (c == CH_PLUS) ? CH_SPACE : c;
         end
      end else if (!nib[4]) begin
         d.outcome = DEC_ERROR;
         d.step    = HEX_IDLE;
         d.high    = 4'd0;
      end else if (step == HEX_FIRST) begin
         d.step = HEX_SECOND;
         d.high = nib[3:0];
      end else begin
         // An escaped zero byte is rejected like a bad digit.
         d.data    = {high, nib[3:0]};
         d.step    = HEX_IDLE;
         d.high    = 4'd0;
         d.outcome = (d.data == 8'd0) ? DEC_ERROR : DEC_BYTE;
      end
      return d;
   endfunction

endpackage

[rtl/urlp_core.sv]
// Input register, parse state and the per-word step logic of the form string parser.
`timescale 1ns / 1ps

module urlp_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [7:0]        req_tdata,   // in_byte [7:0]
   input  logic              req_tlast,   // last
   input  logic [1:0]        source_class,
   input  logic              room,
   output urlp_pkg::push_type push_out
);

   import urlp_pkg::*;

   `include "urlencoded_pair_parser_top_assert.svh"

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_last_ff;

   phase_type  phase_ff, phase_in;
   logic       key_seen_ff, key_seen_in;
   hex_type    hex_step_ff, hex_step_in;
   logic [3:0] hex_high_ff, hex_high_in;
   logic       error_ff, error_in;
   logic       aborted_ff, aborted_in;

   logic       advance;
   logic       delim;
   logic       is_equal;
   logic       key_byte;
   logic       value_byte;
   logic       char_abort;
   decode_type dec;
   logic [1:0] res_n;
   kind_type   res_kind [MAX_RESULTS];
   logic [7:0] res_data [MAX_RESULTS];

   // The held word moves on when the queue can take all of its results.
   assign advance     = in_valid_ff && room;
   assign req_tready  = !in_valid_ff || advance;
   assign delim       = (in_byte_ff == CH_SEMI) || (in_byte_ff == CH_AMP);
   assign is_equal    = (in_byte_ff == CH_EQUAL);
   assign in_valid_in = (req_tvalid && req_tready) ? 1'b1 : (advance ? 1'b0 : in_valid_ff);

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
         in_last_ff <= req_tlast;
      end
   end

   // Parse state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff    <= PH_SKIP;
         key_seen_ff <= 1'b0;
         hex_step_ff <= HEX_IDLE;
         hex_high_ff <= 4'd0;
         error_ff    <= 1'b0;
         aborted_ff  <= 1'b0;
      end else begin
         phase_ff    <= phase_in;
         key_seen_ff <= key_seen_in;
         hex_step_ff <= hex_step_in;
         hex_high_ff <= hex_high_in;
         error_ff    <= error_in;
         aborted_ff  <= aborted_in;
      end
   end

   // One step: the character itself, then the segment verdict, then the stream end.
   always_comb begin
      phase_in    = phase_ff;
      key_seen_in = key_seen_ff;
      hex_step_in = hex_step_ff;
      hex_high_in = hex_high_ff;
      error_in    = error_ff;
      aborted_in  = aborted_ff;
      key_byte    = 1'b0;
      value_byte  = 1'b0;
      char_abort  = 1'b0;
      res_n       = 2'd0;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         res_kind[i] = KIND_KEY;
         res_data[i] = 8'd0;
      end
      dec = decode_char(in_byte_ff, hex_step_ff, hex_high_ff);

      if (advance) begin
         if (!aborted_ff) begin
            // Ordinary characters, by phase of the segment.
            if (!delim) begin
               case (phase_ff)
                  PH_SKIP: begin
                     if (is_equal) begin
                        phase_in    = PH_VALUE;
                        key_seen_in = 1'b0;
                     end else if (in_byte_ff != CH_SPACE) begin
                        phase_in    = PH_KEY;
                        key_seen_in = 1'b1;
                        key_byte    = 1'b1;
                     end
                  end
                  PH_KEY: begin
                     if (is_equal) begin
                        if (error_ff || hex_step_ff != HEX_IDLE) begin
                           char_abort = 1'b1;
                        end else begin
                           phase_in = PH_VALUE;
                        end
                     end else begin
                        key_byte = 1'b1;
                     end
                  end
                  default: begin
                     value_byte = key_seen_ff;
                  end
               endcase

               // A bad escape in the key silences the rest of the key; an equals sign after it aborts.
               if (key_byte && !error_ff) begin
                  hex_step_in = dec.step;
                  hex_high_in = dec.high;
                  if (dec.outcome == DEC_ERROR) begin
                     error_in = 1'b1;
                  end else if (dec.outcome == DEC_BYTE) begin
                     res_kind[res_n] = KIND_KEY;
                     res_data[res_n] = dec.data;
                     res_n           = res_n + 2'd1;
                  end
               end

               // A bad escape in the value aborts at once.
               if (value_byte) begin
                  hex_step_in = dec.step;
                  hex_high_in = dec.high;
                  if (dec.outcome == DEC_ERROR) begin
                     char_abort = 1'b1;
                  end else if (dec.outcome == DEC_BYTE) begin
                     res_kind[res_n] = KIND_VAL;
                     res_data[res_n] = dec.data;
                     res_n           = res_n + 2'd1;
                  end
               end

               if (char_abort) begin
                  res_kind[res_n] = KIND_ABORT;
                  res_n           = res_n + 2'd1;
                  aborted_in      = 1'b1;
                  phase_in        = PH_SKIP;
                  key_seen_in     = 1'b0;
                  hex_step_in     = HEX_IDLE;
                  hex_high_in     = 4'd0;
                  error_in        = 1'b0;
               end
            end

            // Segment verdict at a delimiter, or at the final word if the stream has not aborted.
            if (delim || (in_last_ff && !aborted_in)) begin
               if (phase_in == PH_VALUE && key_seen_in) begin
                  if (hex_step_in != HEX_IDLE) begin
                     res_kind[res_n] = KIND_ABORT;
                     aborted_in      = 1'b1;
                  end else begin
                     res_kind[res_n] = KIND_COMMIT;
                  end
               end else begin
                  res_kind[res_n] = KIND_DROP;
               end
               res_n       = res_n + 2'd1;
               phase_in    = PH_SKIP;
               key_seen_in = 1'b0;
               hex_step_in = HEX_IDLE;
               hex_high_in = 4'd0;
               error_in    = 1'b0;
            end
         end

         // The final word ends the stream and returns to the reset state.
         if (in_last_ff) begin
            res_kind[res_n] = KIND_END;
            res_n           = res_n + 2'd1;
            phase_in        = PH_SKIP;
            key_seen_in     = 1'b0;
            hex_step_in     = HEX_IDLE;
            hex_high_in     = 4'd0;
            error_in        = 1'b0;
            aborted_in      = 1'b0;
         end
      end
   end

   // Pack the results, tagging commits with the class and the final one with run_last.
   always_comb begin
      push_out.count = res_n;
      for (int i = 0; i < MAX_RESULTS; i++) begin
         push_out.entry[i].kind     = res_kind[i];
         push_out.entry[i].data     = res_data[i];
         push_out.entry[i].cls      = (res_kind[i] == KIND_COMMIT) ? source_class : 2'd0;
         push_out.entry[i].run_last = ((2'(i) + 2'd1) == res_n);
      end
   end

   // Results only appear for a word that moves on.
   `URLP_ASSERT_IMPLY(a_push_on_advance, clock, reset, push_out.count != 2'd0, advance)

   // The final word always ends its run with a stream end.
   `URLP_ASSERT_IMPLY(a_last_ends_stream, clock, reset, advance && in_last_ff,
      push_out.count != 2'd0 && push_out.entry[push_out.count - 2'd1].kind == KIND_END)

   // After the final word the parser is back in its reset state.
   `URLP_ASSERT_NEXT(a_last_clears_state, clock, reset, advance && in_last_ff,
      phase_ff == PH_SKIP && !aborted_ff && hex_step_ff == HEX_IDLE && !error_ff)

endmodule

[rtl/urlp_fifo.sv]
// Result queue that takes up to three words a cycle and hands out one when the reader is ready.
`timescale 1ns / 1ps

module urlp_fifo #(
   parameter int DEPTH = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  urlp_pkg::push_type   push_in,
   output logic                 room,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output urlp_pkg::result_type head
);

   import urlp_pkg::*;

   `include "urlencoded_pair_parser_top_assert.svh"

   localparam int PTR_W = $clog2(DEPTH);
   localparam int CNT_W = $clog2(DEPTH + 1);

   result_type       mem [DEPTH];
   logic [PTR_W-1:0] head_ff, head_in;
   logic [PTR_W-1:0] tail_ff, tail_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [PTR_W-1:0] slot [MAX_RESULTS + 1];
   logic [PTR_W:0]   sum;
   logic [PTR_W:0]   head_sum;
   logic             pop;

   assign room      = (count_ff <= CNT_W'(DEPTH - MAX_RESULTS));
   assign rsp_valid = (count_ff != '0);
   assign pop       = rsp_valid && rsp_ready;
   assign head      = mem[head_ff];

   // Write slots from the tail, wrapping at the depth; the slot after the last result is the new tail.
   always_comb begin
      for (int i = 0; i <= MAX_RESULTS; i++) begin
         sum = {1'b0, tail_ff} + (PTR_W + 1)'(i);
         if (sum >= (PTR_W + 1)'(DEPTH)) begin
            sum = sum - (PTR_W + 1)'(DEPTH);
         end
         slot[i] = sum[PTR_W-1:0];
      end
      tail_in = slot[0];
      for (int i = 1; i <= MAX_RESULTS; i++) begin
         if (2'(i) == push_in.count) begin
            tail_in = slot[i];
         end
      end
   end

   // Head advance and occupancy.
   always_comb begin
      head_sum = {1'b0, head_ff} + (PTR_W + 1)'(1);
      if (head_sum >= (PTR_W + 1)'(DEPTH)) begin
         head_sum = head_sum - (PTR_W + 1)'(DEPTH);
      end
      head_in  = pop ? head_sum[PTR_W-1:0] : head_ff;
      count_in = count_ff + CNT_W'(push_in.count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   // Storage writes, one slot per result.
   always_ff @(posedge clock) begin
      for (int i = 0; i < MAX_RESULTS; i++) begin
         if (2'(i) < push_in.count) begin
            mem[slot[i]] <= push_in.entry[i];
         end
      end
   end

   // Occupancy never passes the depth.
   `URLP_ASSERT_IMPLY(a_count_bound, clock, reset, 1'b1, count_ff <= CNT_W'(DEPTH))

   // A push never overruns the free slots.
   `URLP_ASSERT_IMPLY(a_no_overrun, clock, reset, push_in.count != 2'd0,
      (int'(count_ff) + int'(push_in.count)) <= (DEPTH + int'(pop)))

   // A word that waits at the output stays offered and unchanged.
   `URLP_ASSERT_NEXT(a_head_held, clock, reset, rsp_valid && !rsp_ready,
      rsp_valid && $stable(head))

endmodule

[rtl/urlencoded_pair_parser_top.sv]
// Top level of the streaming form and cookie string parser.
`timescale 1ns / 1ps
// Flow: a word is taken into the input register and parsed there; when the result queue
// has room, its results are written into the queue, which offers them on the output.
// Throughput: one input word per cycle while the result queue has room; results are
// handed out one at a time as rsp_tready takes them, buffered by RESULT_DEPTH slots.
// Reset is synchronous and active high: it clears the parse state, empties the
// result queue and sets source_class to 0.

module urlencoded_pair_parser_top #(
   parameter int RESULT_DEPTH = 8
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,    // in_byte [7:0]
   input  logic        req_tlast,    // last
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata,    // data_byte [7:0], pair_class [9:8], zero [15:10]
   output logic [2:0]  rsp_tuser,    // result_kind [2:0]
   output logic        rsp_tlast,    // run_last
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_wr_data   // source_class
);

   import urlp_pkg::*;

   logic [1:0] source_class_ff;
   logic       room;
   push_type   push;
   result_type head;

   // Source class register.
   always_ff @(posedge clock) begin
      if (reset) begin
         source_class_ff <= 2'd0;
      end else if (csr_wr_en) begin
         source_class_ff <= csr_wr_data;
      end
   end

   urlp_core u_core (
      .clock        (clock),
      .reset        (reset),
      .req_tvalid   (req_tvalid),
      .req_tready   (req_tready),
      .req_tdata    (req_tdata),
      .req_tlast    (req_tlast),
      .source_class (source_class_ff),
      .room         (room),
      .push_out     (push)
   );

   urlp_fifo #(
      .DEPTH (RESULT_DEPTH)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_in   (push),
      .room      (room),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .head      (head)
   );

   // Output word packing.
   assign rsp_tdata = {6'd0, head.cls, head.data};
   assign rsp_tuser = head.kind;
   assign rsp_tlast = head.run_last;

endmodule
